// File: hw/rtl/mmh3_pkg.sv
// Package for the MurmurHash3 x86_32 stream hash core.
// Mixing and finaliser constants, controller states, command and status types.
// No dependencies.
package mmh3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam int          PADDR_W    = 3;
    localparam logic        REG_SEED   = 1'b0;
    localparam logic [2:0]  FULL_COUNT = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_FOLD,
        S_FIN0,
        S_FIN1,
        S_FIN2,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_C1,
        MUL_C2,
        MUL_M1,
        MUL_M2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     start_msg;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     fold;
        logic     fin_pre;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic end_msg;
    } dp_status_t;

endpackage

// File: hw/rtl/mmh3_if.sv
// Stream channel interfaces for the hash core: input words and hash results.
// Depends on nothing.
interface mmh3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

interface mmh3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// File: hw/rtl/murmur3_32_stream_hash_core.sv
// MurmurHash3 x86_32 stream hash core: top level with APB seed register.
// Depends on mmh3_pkg, mmh3_if, mmh3_ctrl and mmh3_datapath.
//
// Usage: a message arrives on in_ch as little-endian words with a byte count
// (0..4, values above 4 count as 4) and a last flag. A word with fewer than
// four bytes, or with last set, ends the message; the finalised hash then
// appears on out_ch as one transfer. The seed register (APB, address 0) is
// sampled when the first word of a message is taken.
// Each word is loaded in the idle state, then passes twice through the
// shared 32x32 multiplier and is folded; in_ch.ready is high only in the
// idle state. A final word then runs the finaliser (two multiplier passes)
// and its hash is loaded into the output register.
// The result sits in an output register: while out_ch stalls, the next
// message is still taken; only the following result waits for it to drain.
// Reset clears the seed to 0, the message state and the result valid flag.
module murmur3_32_stream_hash_core
    import mmh3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mmh3_in_if.sink            in_ch,
    mmh3_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] seed_reg, seed_next;
    logic        seed_wr;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);

    always_comb
    begin
        seed_next = seed_wr ? pwdata : seed_reg;
        prdata    = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mmh3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    mmh3_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .seed       (seed_reg),
        .data_word  (in_ch.data_word),
        .byte_count (in_ch.byte_count),
        .last       (in_ch.last),
        .hash_value (out_ch.hash_value)
    );

endmodule

// File: hw/rtl/mmh3_datapath.sv
// Datapath of the hash core: word mixing through one shared multiplier,
// running hash and length registers, finaliser and result register. Uses mmh3_pkg.
module mmh3_datapath
    import mmh3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [31:0] seed,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic [31:0] hash_value
);

    logic [31:0] k_reg, k_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        end_reg, end_next;
    logic [31:0] hash_reg, hash_next;

    logic [2:0]  cnt_in;
    logic [31:0] mask;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] h_x, h_rot, h_fold;
    logic [31:0] f_x;

    always_comb
    begin
        cnt_in = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
        unique case (cnt_in)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_C1:
            begin
                mul_a = k_reg;
                mul_b = MIX_C1;
            end
            MUL_C2:
            begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = MIX_C2;
            end
            MUL_M1:
            begin
                mul_a = k_reg;
                mul_b = FIN_M1;
            end
            default:
            begin
                mul_a = k_reg ^ (k_reg >> 13);
                mul_b = FIN_M2;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        h_x    = h_reg ^ k_reg;
        h_rot  = {h_x[18:0], h_x[31:19]};
        h_fold = (cnt_reg == FULL_COUNT) ? ((h_rot << 2) + h_rot + MIX_ADD) : h_x;
        f_x    = h_reg ^ len_reg;
    end

    always_comb
    begin
        k_next    = k_reg;
        h_next    = h_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        hash_next = hash_reg;
        if (cmd.load)
        begin
            k_next   = data_word & mask;
            cnt_next = cnt_in;
            end_next = last || (cnt_in != FULL_COUNT);
            if (cmd.start_msg)
            begin
                h_next   = seed;
                len_next = '0;
            end
        end
        if (cmd.mul_en)
        begin
            k_next = prod;
        end
        if (cmd.fold)
        begin
            h_next   = h_fold;
            len_next = len_reg + {29'd0, cnt_reg};
        end
        if (cmd.fin_pre)
        begin
            k_next = f_x ^ (f_x >> 16);
        end
        if (cmd.out_load)
        begin
            hash_next = k_reg ^ (k_reg >> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        h_reg    <= h_next;
        cnt_reg  <= cnt_next;
        end_reg  <= end_next;
        hash_reg <= hash_next;
    end

    assign status.end_msg = end_reg;
    assign hash_value     = hash_reg;

endmodule

// File: hw/rtl/mmh3_ctrl.sv
// Controller of the hash core: sequences load, mix, fold and finalise steps
// and holds the message and result flags. Uses mmh3_pkg.
module mmh3_ctrl
    import mmh3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        in_msg_reg, in_msg_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_C1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.start_msg = !in_msg_reg;
                    in_msg_next   = 1'b1;
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C2;
                state_next  = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (status.end_msg)
                begin
                    in_msg_next = 1'b0;
                    state_next  = S_FIN0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN0:
            begin
                cmd.fin_pre = 1'b1;
                state_next  = S_FIN1;
            end
            S_FIN1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_M1;
                state_next  = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_M2;
                state_next  = S_OUT;
            end
            default:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/mmh3_checker.sv
// Port-level checks for the hash core, bound to the top level.
// Depends on murmur3_32_stream_hash_core.
module mmh3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] hash_value,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hash_value))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word taken while previous still in work");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without finaliser pass");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind murmur3_32_stream_hash_core mmh3_checker u_mmh3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .hash_value (out_ch.hash_value),
    .pready     (pready)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for murmur3_32_stream_hash_core: random and directed messages
// checked against an in-bench hash predictor. Uses mmh3_pkg, mmh3_if, core RTL.
module tb_top;
    import mmh3_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEM_TARGET  = 750;
    localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(4 * int'(REG_SEED));

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    mmh3_in_if  in_ch ();
    mmh3_out_if out_ch ();

    murmur3_32_stream_hash_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [31:0] seed_shadow;
    logic [31:0] run_hash;
    logic [31:0] run_length;
    bit          msg_open;
    logic [31:0] pending_hashes[$];
    int          mismatch_count;
    int          sent_items;
    int          in_idle_pct;
    int          out_idle_pct;
    int          hold_off_left;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] mix_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = {t[16:0], t[31:17]};
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        return t ^ (t >> 16);
    endfunction

    // Fold one accepted transfer into the running hash; queue a hash at message end
    function automatic void absorb_word(input logic [31:0] w, input logic [2:0] cnt,
                                        input logic lst);
        logic [2:0]  n;
        logic [31:0] mask;
        logic [31:0] h;
        n = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
        if (!msg_open)
        begin
            run_hash   = seed_shadow;
            run_length = 32'd0;
            msg_open   = 1'b1;
        end
        h = run_hash;
        if (n == FULL_COUNT)
        begin
            h = h ^ mix_block(w);
            h = {h[18:0], h[31:19]};
            h = h * 32'd5 + MIX_ADD;
        end
        else if (n != 3'd0)
        begin
            mask = (32'h1 << (8 * n)) - 32'h1;
            h    = h ^ mix_block(w & mask);
        end
        run_hash   = h;
        run_length = run_length + 32'(n);
        if (n != FULL_COUNT || lst)
        begin
            pending_hashes.push_back(finish_hash(run_hash ^ run_length));
            msg_open = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.data_word <= $urandom;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_word  <= w;
        in_ch.byte_count <= cnt;
        in_ch.last       <= lst;
        do @(posedge clk); while (!in_ch.ready);
        absorb_word(w, cnt, lst);
        sent_items++;
    endtask

    task automatic send_random_message(input int max_words);
        int         n;
        int         kind;
        logic [2:0] cnt;
        n = $urandom_range(max_words);
        repeat (n)
        begin
            cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : FULL_COUNT;
            send_word($urandom, cnt, 1'b0);
        end
        kind = $urandom_range(9);
        if (kind < 5)
            send_word($urandom, 3'($urandom_range(3)), 1'($urandom));
        else if (kind < 8)
            send_word($urandom, FULL_COUNT, 1'b1);
        else
            send_word($urandom, 3'($urandom_range(7, 5)), 1'b1);
    endtask

    // Drop valid, wait for every expected hash, then let the core go quiet
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic read_seed();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SEED_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== seed_shadow)
            report_mismatch($sformatf("seed readback %08h, expected %08h",
                                      prdata, seed_shadow));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        seed_shadow = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_seed();
    endtask

    task automatic test_reset_seed();
        read_seed();
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h0000_0000, FULL_COUNT, 1'b1);
        settle();
    endtask

    task automatic test_directed_words();
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'hffff_ffff, FULL_COUNT, 1'b1);
        send_word(32'h1234_5678, 3'd5, 1'b0);
        send_word(32'h9abc_def0, 3'd6, 1'b0);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        send_word(32'hdead_beef, FULL_COUNT, 1'b0);
        send_word(32'hcafe_f00d, FULL_COUNT, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'ha5a5_a5a5, FULL_COUNT, 1'b0);
        send_word(32'hffff_ff5a, 3'd3, 1'b0);
        settle();
        write_seed(32'hffff_ffff);
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, FULL_COUNT, 1'b1);
        send_word(32'h8000_0000, FULL_COUNT, 1'b0);
        send_word(32'h0000_0001, 3'd2, 1'b1);
        send_word(32'h5a5a_5a5a, 3'd1, 1'b0);
        settle();
    endtask

    task automatic test_seed_sweep();
        logic [31:0] seeds[5];
        int          start;
        seeds = '{32'h8000_0000, 32'h0000_0001, $urandom, 32'hffff_ffff, 32'h0000_0000};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            start = sent_items;
            while (sent_items - start < 30)
                send_random_message(4);
            settle();
        end
    endtask

    task automatic test_output_stall();
        @(posedge clk);
        hold_off_left = 400;
        repeat (12) send_random_message(3);
        settle();
    endtask

    task automatic test_random_stream();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        while (sent_items < 360)
            send_random_message(($urandom_range(7) == 0) ? 16 : 4);
        settle();
        write_seed($urandom);
        in_idle_pct  = 29;
        out_idle_pct = 29;
        while (sent_items < ITEM_TARGET)
            send_random_message(($urandom_range(7) == 0) ? 16 : 4);
        settle();
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off_left--;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected hash %08h", out_ch.hash_value));
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (out_ch.hash_value !== want)
                    report_mismatch($sformatf("hash_value %08h, expected %08h",
                                              out_ch.hash_value, want));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = 32'd0;
        in_ch.valid      = 1'b0;
        in_ch.data_word  = 32'd0;
        in_ch.byte_count = 3'd0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        seed_shadow      = 32'd0;
        run_hash         = 32'd0;
        run_length       = 32'd0;
        msg_open         = 1'b0;
        mismatch_count   = 0;
        sent_items       = 0;
        in_idle_pct      = 29;
        out_idle_pct     = 29;
        hold_off_left    = 0;
        cycle_count      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_seed();
        test_directed_words();
        test_seed_sweep();
        test_output_stall();
        test_random_stream();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: murmur3_32_stream_hash_core.f
hw/rtl/mmh3_pkg.sv
hw/rtl/mmh3_if.sv
hw/rtl/mmh3_datapath.sv
hw/rtl/mmh3_ctrl.sv
hw/rtl/murmur3_32_stream_hash_core.sv
hw/rtl/mmh3_checker.sv
dv/tb_top.sv
